>>> src/gmr_pkg.sv
// Shared types and codes for the grid maze shortest-path router.
// Used by the controller, the datapath and the top level.
package gmr_pkg;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_STEP   = 1'b1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ROW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_COL   = 3'd5;

  localparam int LEN_W   = 11;
  localparam int COORD_W = 5;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_FETCH    = 4'd2;
  localparam logic [3:0] OP_INIT     = 4'd3;
  localparam logic [3:0] OP_CHK_S    = 4'd4;
  localparam logic [3:0] OP_SEED     = 4'd5;
  localparam logic [3:0] OP_POP      = 4'd6;
  localparam logic [3:0] OP_CUR      = 4'd7;
  localparam logic [3:0] OP_PROBE    = 4'd8;
  localparam logic [3:0] OP_VISIT    = 4'd9;
  localparam logic [3:0] OP_TB_INIT  = 4'd10;
  localparam logic [3:0] OP_TB_CHECK = 4'd11;
  localparam logic [3:0] OP_TB_DONE  = 4'd12;
  localparam logic [3:0] OP_EMIT_ST  = 4'd13;
  localparam logic [3:0] OP_EMIT_STP = 4'd14;

  typedef struct packed {
    logic [3:0] op;
    logic [1:0] dir;
  } cmd_t;

  typedef struct packed {
    logic load_last;
    logic range_ok;
    logic wall_rd;
    logic reached;
    logic queue_empty;
    logic tb_match;
    logic tb_last;
    logic e_at_start;
    logic out_free;
  } sts_t;

endpackage

>>> src/gmr_in_if.sv
// Input channel of the maze router: valid, ready and one input beat.
// Depends on nothing.
interface gmr_in_if;
  logic valid;
  logic ready;
  logic action;
  logic cell_wall;

  modport source(output valid, action, cell_wall, input ready);
  modport sink(input valid, action, cell_wall, output ready);
endinterface

>>> src/gmr_out_if.sv
// Result channel of the maze router: valid, ready and one result beat.
// Depends on nothing.
interface gmr_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        found;
  logic [10:0] path_length;
  logic        step_valid;
  logic [4:0]  row;
  logic [4:0]  col;
  logic        last_step;

  modport source(output valid, kind, found, path_length, step_valid, row, col, last_step,
                 input ready);
  modport sink(input valid, kind, found, path_length, step_valid, row, col, last_step,
               output ready);
endinterface

>>> src/gmr_ctrl.sv
// Controller of the maze router: sequences loads, fetches, search and traceback.
// Depends on gmr_pkg for command and status types.
module gmr_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_action,
  output logic          in_ready,
  input  gmr_pkg::sts_t sts,
  output gmr_pkg::cmd_t cmd
);

  localparam logic [3:0] C_IDLE     = 4'd0;
  localparam logic [3:0] C_FETCH    = 4'd1;
  localparam logic [3:0] C_INIT     = 4'd2;
  localparam logic [3:0] C_CHK_S    = 4'd3;
  localparam logic [3:0] C_CHK_E    = 4'd4;
  localparam logic [3:0] C_POP      = 4'd5;
  localparam logic [3:0] C_CUR      = 4'd6;
  localparam logic [3:0] C_PROBE    = 4'd7;
  localparam logic [3:0] C_VISIT    = 4'd8;
  localparam logic [3:0] C_TB_INIT  = 4'd9;
  localparam logic [3:0] C_TB_PROBE = 4'd10;
  localparam logic [3:0] C_TB_CHECK = 4'd11;
  localparam logic [3:0] C_TB_DONE  = 4'd12;
  localparam logic [3:0] C_STATUS   = 4'd13;

  logic [3:0] state, state_next;
  logic [1:0] dir, dir_next;

  assign in_ready = (state == C_IDLE);

  always_comb begin
    state_next = state;
    dir_next   = dir;
    cmd.op     = gmr_pkg::OP_NONE;
    cmd.dir    = dir;
    case (state)
      C_IDLE: begin
        if (in_valid) begin
          if (in_action == gmr_pkg::ACT_LOAD) begin
            cmd.op = gmr_pkg::OP_LOAD;
            if (sts.load_last) state_next = C_INIT;
          end else begin
            cmd.op     = gmr_pkg::OP_FETCH;
            state_next = C_FETCH;
          end
        end
      end
      C_FETCH: begin
        if (sts.out_free) begin
          cmd.op     = gmr_pkg::OP_EMIT_STP;
          state_next = C_IDLE;
        end
      end
      C_INIT: begin
        cmd.op     = gmr_pkg::OP_INIT;
        state_next = sts.range_ok ? C_CHK_S : C_STATUS;
      end
      C_CHK_S: begin
        cmd.op     = gmr_pkg::OP_CHK_S;
        state_next = sts.wall_rd ? C_STATUS : C_CHK_E;
      end
      C_CHK_E: begin
        cmd.op     = gmr_pkg::OP_SEED;
        state_next = sts.wall_rd ? C_STATUS : C_POP;
      end
      C_POP: begin
        if (sts.reached) begin
          state_next = C_TB_INIT;
        end else if (sts.queue_empty) begin
          state_next = C_STATUS;
        end else begin
          cmd.op     = gmr_pkg::OP_POP;
          state_next = C_CUR;
        end
      end
      C_CUR: begin
        cmd.op     = gmr_pkg::OP_CUR;
        dir_next   = gmr_pkg::DIR_UP;
        state_next = C_PROBE;
      end
      C_PROBE: begin
        cmd.op     = gmr_pkg::OP_PROBE;
        state_next = C_VISIT;
      end
      C_VISIT: begin
        cmd.op = gmr_pkg::OP_VISIT;
        if (dir == gmr_pkg::DIR_LEFT) begin
          state_next = C_POP;
        end else begin
          dir_next   = dir + 2'd1;
          state_next = C_PROBE;
        end
      end
      C_TB_INIT: begin
        cmd.op     = gmr_pkg::OP_TB_INIT;
        dir_next   = gmr_pkg::DIR_UP;
        state_next = sts.e_at_start ? C_TB_DONE : C_TB_PROBE;
      end
      C_TB_PROBE: begin
        cmd.op     = gmr_pkg::OP_PROBE;
        state_next = C_TB_CHECK;
      end
      C_TB_CHECK: begin
        cmd.op = gmr_pkg::OP_TB_CHECK;
        if (sts.tb_match || dir == gmr_pkg::DIR_LEFT) begin
          dir_next   = gmr_pkg::DIR_UP;
          state_next = sts.tb_last ? C_TB_DONE : C_TB_PROBE;
        end else begin
          dir_next   = dir + 2'd1;
          state_next = C_TB_PROBE;
        end
      end
      C_TB_DONE: begin
        cmd.op     = gmr_pkg::OP_TB_DONE;
        state_next = C_STATUS;
      end
      C_STATUS: begin
        if (sts.out_free) begin
          cmd.op     = gmr_pkg::OP_EMIT_ST;
          state_next = C_IDLE;
        end
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      dir   <= gmr_pkg::DIR_UP;
    end else begin
      state <= state_next;
      dir   <= dir_next;
    end
  end

endmodule

>>> src/gmr_dp.sv
// Datapath of the maze router: registers, grid and mark memories, queue, path store
// and the result register. Depends on gmr_pkg; driven by gmr_ctrl commands.
module gmr_dp #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gmr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gmr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             cell_wall,
  input  gmr_pkg::cmd_t                    cmd,
  output gmr_pkg::sts_t                    sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             out_kind,
  output logic                             out_found,
  output logic [gmr_pkg::LEN_W-1:0]        out_path_length,
  output logic                             out_step_valid,
  output logic [gmr_pkg::COORD_W-1:0]      out_row,
  output logic [gmr_pkg::COORD_W-1:0]      out_col,
  output logic                             out_last_step
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int NCW   = $clog2(MAX_COLS + 1);
  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int TW    = $clog2(CELLS + 1);

  logic [5:0] grid_rows, grid_cols;
  logic [4:0] start_row, start_col, end_row, end_col;

  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;
  logic [TW-1:0]  total;
  logic [RW-1:0]  s_r, e_r;
  logic [CW-1:0]  s_c, e_c;

  logic           wall_mem  [CELLS];
  logic [AW:0]    mark_mem  [CELLS];
  logic [RW+CW+AW-1:0] queue_mem [CELLS];
  logic [RW+CW-1:0]    path_mem  [CELLS];

  logic [AW-1:0]  load_pos;
  logic           path_found;
  logic [TW-1:0]  path_cells;
  logic [TW-1:0]  read_pos;
  logic [TW-1:0]  head, tail;
  logic           reached;
  logic [AW-1:0]  e_dist;
  logic [AW-1:0]  tb_d;

  logic [RW-1:0]  cur_r, nb_r, pr_r, a_r;
  logic [CW-1:0]  cur_c, nb_c, pr_c, a_c;
  logic [AW-1:0]  cur_d;
  logic           nb_ok, pr_ok;
  logic [AW-1:0]  lin, nb_addr;
  logic           wall_rd;
  logic [AW:0]    mark_rd;
  logic [RW+CW+AW-1:0] q_rd;
  logic [RW+CW-1:0]    p_rd;
  logic           fetch_ok, fetch_last;
  logic           enq, tb_match, tb_adv;
  logic [AW-1:0]  d_inc;

  always_comb begin
    if (grid_rows == 6'd0) nr = NRW'(1);
    else if (int'(grid_rows) > MAX_ROWS) nr = NRW'(MAX_ROWS);
    else nr = NRW'(grid_rows);
    if (grid_cols == 6'd0) nc = NCW'(1);
    else if (int'(grid_cols) > MAX_COLS) nc = NCW'(MAX_COLS);
    else nc = NCW'(grid_cols);
  end

  assign total = TW'(int'(nr) * int'(nc));
  assign s_r   = RW'(start_row);
  assign s_c   = CW'(start_col);
  assign e_r   = RW'(end_row);
  assign e_c   = CW'(end_col);
  assign d_inc = cur_d + AW'(1);

  always_comb begin
    pr_r  = cur_r;
    pr_c  = cur_c;
    pr_ok = 1'b0;
    case (cmd.dir)
      gmr_pkg::DIR_UP: begin
        pr_ok = (cur_r != '0);
        pr_r  = cur_r - RW'(1);
      end
      gmr_pkg::DIR_DOWN: begin
        pr_ok = (int'(cur_r) + 1 < int'(nr));
        pr_r  = cur_r + RW'(1);
      end
      gmr_pkg::DIR_RIGHT: begin
        pr_ok = (int'(cur_c) + 1 < int'(nc));
        pr_c  = cur_c + CW'(1);
      end
      gmr_pkg::DIR_LEFT: begin
        pr_ok = (cur_c != '0);
        pr_c  = cur_c - CW'(1);
      end
      default: begin
        pr_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.op)
      gmr_pkg::OP_INIT, gmr_pkg::OP_SEED: begin
        a_r = s_r;
        a_c = s_c;
      end
      gmr_pkg::OP_CHK_S: begin
        a_r = e_r;
        a_c = e_c;
      end
      gmr_pkg::OP_PROBE: begin
        a_r = pr_r;
        a_c = pr_c;
      end
      default: begin
        a_r = '0;
        a_c = '0;
      end
    endcase
  end

  assign lin      = AW'(int'(a_r) * int'(nc) + int'(a_c));
  assign enq      = nb_ok && !wall_rd && !mark_rd[AW];
  assign tb_match = nb_ok && !wall_rd && mark_rd[AW] && (mark_rd[AW-1:0] == tb_d - AW'(1));
  assign tb_adv   = tb_match || (cmd.dir == gmr_pkg::DIR_LEFT);

  assign sts.load_last   = (int'(load_pos) + 1 >= int'(total));
  assign sts.range_ok    = (int'(start_row) < int'(nr)) && (int'(start_col) < int'(nc)) &&
                           (int'(end_row) < int'(nr)) && (int'(end_col) < int'(nc));
  assign sts.wall_rd     = wall_rd;
  assign sts.reached     = reached;
  assign sts.queue_empty = (head == tail);
  assign sts.tb_match    = tb_match;
  assign sts.tb_last     = (tb_d == AW'(1));
  assign sts.e_at_start  = (e_dist == '0);
  assign sts.out_free    = !out_valid || out_ready;

  // Memories: one write and one read address each per cycle.
  always_ff @(posedge clk) begin
    wall_rd <= wall_mem[lin];
    mark_rd <= mark_mem[lin];
    if (cmd.op == gmr_pkg::OP_LOAD && int'(load_pos) < int'(total)) begin
      wall_mem[load_pos] <= cell_wall;
    end
    if (cmd.op == gmr_pkg::OP_LOAD && int'(load_pos) < int'(total)) begin
      mark_mem[load_pos] <= '0;
    end else if (cmd.op == gmr_pkg::OP_SEED && !wall_rd) begin
      mark_mem[lin] <= {1'b1, AW'(0)};
    end else if (cmd.op == gmr_pkg::OP_VISIT && enq) begin
      mark_mem[nb_addr] <= {1'b1, d_inc};
    end
    if (cmd.op == gmr_pkg::OP_SEED && !wall_rd) begin
      queue_mem[0] <= {s_r, s_c, AW'(0)};
    end else if (cmd.op == gmr_pkg::OP_VISIT && enq) begin
      queue_mem[tail[AW-1:0]] <= {nb_r, nb_c, d_inc};
    end
    if (cmd.op == gmr_pkg::OP_POP) begin
      q_rd <= queue_mem[head[AW-1:0]];
    end
    if (cmd.op == gmr_pkg::OP_TB_INIT) begin
      path_mem[e_dist] <= {e_r, e_c};
    end else if (cmd.op == gmr_pkg::OP_TB_CHECK && tb_adv) begin
      path_mem[tb_d - AW'(1)] <= tb_match ? {nb_r, nb_c} : {cur_r, cur_c};
    end
    if (cmd.op == gmr_pkg::OP_FETCH) begin
      p_rd <= path_mem[read_pos[AW-1:0]];
    end
  end

  // Search and traceback working registers.
  always_ff @(posedge clk) begin
    case (cmd.op)
      gmr_pkg::OP_SEED: begin
        head    <= '0;
        tail    <= TW'(1);
        reached <= (s_r == e_r) && (s_c == e_c);
        e_dist  <= '0;
      end
      gmr_pkg::OP_POP: begin
        head <= head + TW'(1);
      end
      gmr_pkg::OP_CUR: begin
        cur_r <= q_rd[RW+CW+AW-1:CW+AW];
        cur_c <= q_rd[CW+AW-1:AW];
        cur_d <= q_rd[AW-1:0];
      end
      gmr_pkg::OP_PROBE: begin
        nb_r    <= pr_r;
        nb_c    <= pr_c;
        nb_ok   <= pr_ok;
        nb_addr <= lin;
      end
      gmr_pkg::OP_VISIT: begin
        if (enq) begin
          tail <= tail + TW'(1);
          if (nb_r == e_r && nb_c == e_c) begin
            reached <= 1'b1;
            e_dist  <= d_inc;
          end
        end
      end
      gmr_pkg::OP_TB_INIT: begin
        cur_r <= e_r;
        cur_c <= e_c;
        tb_d  <= e_dist;
      end
      gmr_pkg::OP_TB_CHECK: begin
        if (tb_adv) begin
          tb_d <= tb_d - AW'(1);
          if (tb_match) begin
            cur_r <= nb_r;
            cur_c <= nb_c;
          end
        end
      end
      default: begin
      end
    endcase
    if (cmd.op == gmr_pkg::OP_FETCH) begin
      fetch_ok   <= path_found && (read_pos < path_cells);
      fetch_last <= (read_pos + TW'(1) == path_cells);
    end
  end

  // Configuration, positions and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows  <= 6'd32;
      grid_cols  <= 6'd32;
      start_row  <= '0;
      start_col  <= '0;
      end_row    <= '0;
      end_col    <= '0;
      load_pos   <= '0;
      path_found <= 1'b0;
      path_cells <= '0;
      read_pos   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gmr_pkg::CFG_GRID_ROWS: grid_rows <= cfg_data;
          gmr_pkg::CFG_GRID_COLS: grid_cols <= cfg_data;
          gmr_pkg::CFG_START_ROW: start_row <= cfg_data[4:0];
          gmr_pkg::CFG_START_COL: start_col <= cfg_data[4:0];
          gmr_pkg::CFG_END_ROW:   end_row   <= cfg_data[4:0];
          gmr_pkg::CFG_END_COL:   end_col   <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
      if (cmd.op == gmr_pkg::OP_EMIT_ST || cmd.op == gmr_pkg::OP_EMIT_STP) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        gmr_pkg::OP_LOAD: begin
          load_pos <= sts.load_last ? '0 : load_pos + AW'(1);
        end
        gmr_pkg::OP_INIT: begin
          path_found <= 1'b0;
          path_cells <= '0;
          read_pos   <= '0;
        end
        gmr_pkg::OP_TB_DONE: begin
          path_found <= 1'b1;
          path_cells <= TW'(e_dist) + TW'(1);
        end
        gmr_pkg::OP_FETCH: begin
          if (path_found && read_pos < path_cells) read_pos <= read_pos + TW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == gmr_pkg::OP_EMIT_ST) begin
      out_kind        <= gmr_pkg::KIND_STATUS;
      out_found       <= path_found;
      out_path_length <= gmr_pkg::LEN_W'(path_cells);
      out_step_valid  <= 1'b0;
      out_row         <= '0;
      out_col         <= '0;
      out_last_step   <= 1'b0;
    end else if (cmd.op == gmr_pkg::OP_EMIT_STP) begin
      out_kind        <= gmr_pkg::KIND_STEP;
      out_found       <= path_found;
      out_path_length <= gmr_pkg::LEN_W'(path_cells);
      out_step_valid  <= fetch_ok;
      out_row         <= fetch_ok ? gmr_pkg::COORD_W'(p_rd[RW+CW-1:CW]) : '0;
      out_col         <= fetch_ok ? gmr_pkg::COORD_W'(p_rd[CW-1:0]) : '0;
      out_last_step   <= fetch_ok && fetch_last;
    end
  end

endmodule

>>> src/grid_maze_shortest_path_router_top.sv
// Top level of the grid maze shortest-path router: controller plus datapath.
// Depends on gmr_pkg, gmr_in_if, gmr_out_if, gmr_ctrl and gmr_dp.
//
//   port      dir  handshake       beat
//   in_ch     in   valid/ready     action, cell_wall
//   out_ch    out  valid/ready     kind, found, path_length, step_valid, row, col, last_step
//   cfg_*     in   cfg_we only     cfg_index, cfg_data
//
// A load writes one grid cell; a fetch reads the path store, then waits for the result register.
// The load that completes the grid starts a search that takes cells from the frontier queue
// and probes their four neighbours, then traces the path back cell by cell, all paced by the
// single read port of the mark memory. Reset is synchronous; the memories need no clear.
// Input is refused while a search runs or while a result waits for its slot.
module grid_maze_shortest_path_router_top #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  gmr_in_if.sink                         in_ch,
  gmr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [gmr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gmr_pkg::CFG_DATA_W-1:0] cfg_data
);

  gmr_pkg::cmd_t cmd;
  gmr_pkg::sts_t sts;
  logic          ready;

  assign in_ch.ready = ready;

  gmr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  gmr_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cell_wall       (in_ch.cell_wall),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_kind        (out_ch.kind),
    .out_found       (out_ch.found),
    .out_path_length (out_ch.path_length),
    .out_step_valid  (out_ch.step_valid),
    .out_row         (out_ch.row),
    .out_col         (out_ch.col),
    .out_last_step   (out_ch.last_step)
  );

endmodule
